// ===== src/dlle_pkg.sv =====
package dlle_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int HANDLE_W = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_DELETE     = 3'd5
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HND = 2'd3;

  // result kinds: plain/status, search hit, search miss
  localparam logic [1:0] RES_PLAIN = 2'd0;
  localparam logic [1:0] RES_HIT   = 2'd1;
  localparam logic [1:0] RES_MISS  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch input transaction
    logic rd_node;    // read links/value of target node (cur)
    logic walk_start; // load cur from target node (head on search)
    logic walk_step;  // search: advance cur to next link
    logic push_exec;  // perform push writes
    logic drop_exec;  // perform unlink writes
    logic res_load;   // latch result fields
  } dlle_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic list_empty;
    logic pool_full;
    logic hnd_bad;
    logic cur_nil;
    logic cur_match;
  } dlle_stat_t;

endpackage

// ===== src/dlle_ctrl.sv =====
module dlle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dlle_pkg::dlle_stat_t st,
  output dlle_pkg::dlle_cmd_t  ctl,
  output logic [1:0]          res_kind
);
  import dlle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   res_pend;   // result register full

  // next state and datapath commands
  always_comb begin
    ctl        = '0;
    res_kind   = RES_PLAIN;
    state_next = state;
    in_ready   = (state == S_IDLE) && !res_pend;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        // node memory read of target (pop/delete) or head (search)
        ctl.rd_node    = 1'b1;
        ctl.walk_start = 1'b1;
        state_next     = (st.cmd == CMD_SEARCH) ? S_WALK : S_EXEC;
      end
      S_EXEC: begin
        ctl.res_load = 1'b1;
        case (st.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: ctl.push_exec = !st.pool_full;
          CMD_POP_FRONT, CMD_POP_BACK:   ctl.drop_exec = !st.list_empty;
          CMD_DELETE: ctl.drop_exec = !st.list_empty && !st.hnd_bad;
          default: ;
        endcase
        state_next = S_DONE;
      end
      S_WALK: begin
        if (st.cur_nil) begin
          ctl.res_load = 1'b1;
          res_kind     = RES_MISS;
          state_next   = S_DONE;
        end else if (st.cur_match) begin
          ctl.res_load = 1'b1;
          res_kind     = RES_HIT;
          state_next   = S_DONE;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.res_load) res_pend <= 1'b1;
      else if (out_ready) res_pend <= 1'b0;
    end
  end

  assign out_valid = res_pend;

endmodule

// ===== src/dlle_dpath.sv =====
module dlle_dpath #(
  parameter int NODES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [dlle_pkg::CMD_W-1:0]     in_cmd,
  input  logic [dlle_pkg::VALUE_W-1:0]   in_value,
  input  logic [dlle_pkg::HANDLE_W-1:0]  in_handle,
  input  dlle_pkg::dlle_cmd_t            ctl,
  input  logic [1:0]                     res_kind,
  output dlle_pkg::dlle_stat_t           st,
  output logic [dlle_pkg::VALUE_W-1:0]   res_data,
  output logic [dlle_pkg::HANDLE_W-1:0]  res_handle,
  output logic                           res_found,
  output logic [dlle_pkg::STATUS_W-1:0]  res_status,
  output logic                           res_empty,
  output logic                           res_full
);
  import dlle_pkg::*;

  localparam int AW = $clog2(NODES + 1);     // link width incl. null
  localparam int IW = $clog2(NODES);         // index width
  localparam logic [AW-1:0] NIL = AW'(NODES);

  // node memories; a link entry holds (next, prev)
  logic [VALUE_W-1:0] val_mem [NODES];
  logic [AW-1:0]      nxt_mem [NODES];
  logic [AW-1:0]      prv_mem [NODES];
  logic [NODES-1:0]   live;
  logic [NODES-1:0]   nxt_ok; // next link written since reset

  logic [AW-1:0] head, tail, free_head, count;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] val;
  logic [HANDLE_W-1:0] hnd;
  logic [AW-1:0] cur;
  logic [VALUE_W-1:0] rd_val;
  logic [AW-1:0] rd_nxt, rd_prv, fh_nxt;
  logic          hnd_bad;

  // target node chosen from the command
  logic [AW-1:0] tgt;
  always_comb begin
    case (cmd)
      CMD_POP_FRONT, CMD_SEARCH: tgt = head;
      CMD_POP_BACK:              tgt = tail;
      default:                   tgt = AW'(hnd);
    endcase
  end

  logic [IW-1:0] tgt_i, fh_i;
  assign tgt_i = tgt[IW-1:0];
  assign fh_i  = free_head[IW-1:0];

  // search cursor walk; read addr is target at start, next link otherwise
  logic [IW-1:0] rd_i;
  assign rd_i  = ctl.walk_step ? rd_nxt[IW-1:0] : tgt_i;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd <= in_cmd;
      val <= in_value;
      hnd <= in_handle;
    end
    if (ctl.walk_start) cur <= tgt;
    else if (ctl.walk_step) cur <= rd_nxt;
    if (ctl.rd_node || ctl.walk_step) begin
      rd_val <= val_mem[rd_i];
      rd_nxt <= nxt_ok[rd_i] ? nxt_mem[rd_i] : AW'(rd_i) + AW'(1);
      rd_prv <= prv_mem[rd_i];
    end
    if (ctl.rd_node)
      fh_nxt <= nxt_ok[fh_i] ? nxt_mem[fh_i] : AW'(fh_i) + AW'(1);
  end

  // handle range check at full handle width, plus liveness of the target node
  assign hnd_bad = (int'(hnd) >= NODES) || !live[tgt_i];
  assign st.cmd        = cmd;
  assign st.list_empty = (head == NIL);
  assign st.pool_full  = (count >= NIL) || (free_head == NIL);
  assign st.hnd_bad    = hnd_bad;
  assign st.cur_nil    = (cur == NIL);
  assign st.cur_match  = (rd_val == val);

  // list update writes
  always_ff @(posedge clk) begin
    if (ctl.push_exec) begin
      val_mem[fh_i] <= val;
      if (cmd == CMD_PUSH_FRONT) begin
        prv_mem[fh_i] <= NIL;
        nxt_mem[fh_i] <= head;
        if (head != NIL) prv_mem[head[IW-1:0]] <= free_head;
      end else begin
        nxt_mem[fh_i] <= NIL;
        prv_mem[fh_i] <= tail;
        if (tail != NIL) nxt_mem[tail[IW-1:0]] <= free_head;
      end
    end
    if (ctl.drop_exec) begin
      if (rd_prv != NIL) nxt_mem[rd_prv[IW-1:0]] <= rd_nxt;
      if (rd_nxt != NIL) prv_mem[rd_nxt[IW-1:0]] <= rd_prv;
      nxt_mem[tgt_i] <= free_head;
    end
  end

  // pointer and flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      count     <= '0;
      live      <= '0;
      nxt_ok    <= '0;
    end else begin
      if (ctl.push_exec) begin
        live[fh_i]   <= 1'b1;
        nxt_ok[fh_i] <= 1'b1;
        free_head    <= fh_nxt;
        count        <= count + AW'(1);
        if (cmd == CMD_PUSH_FRONT) begin
          if (head != NIL) nxt_ok[head[IW-1:0]] <= nxt_ok[head[IW-1:0]];
          if (head == NIL) tail <= free_head;
          head <= free_head;
        end else begin
          if (tail != NIL) nxt_ok[tail[IW-1:0]] <= 1'b1;
          if (tail == NIL) head <= free_head;
          tail <= free_head;
        end
      end
      if (ctl.drop_exec) begin
        if (rd_prv == NIL) head <= rd_nxt;
        else nxt_ok[rd_prv[IW-1:0]] <= 1'b1;
        if (rd_nxt == NIL) tail <= rd_prv;
        live[tgt_i]   <= 1'b0;
        nxt_ok[tgt_i] <= 1'b1;
        free_head     <= tgt;
        count         <= count - AW'(1);
      end
    end
  end

  // post-step flags, from the state after the update
  logic           drop_now;
  logic [AW-1:0]  head_after, count_after;
  assign drop_now = ctl.drop_exec;
  always_comb begin
    head_after  = head;
    count_after = count;
    if (ctl.push_exec) begin
      count_after = count + AW'(1);
      if (cmd == CMD_PUSH_FRONT || head == NIL) head_after = free_head;
    end
    if (drop_now) begin
      count_after = count - AW'(1);
      if (rd_prv == NIL) head_after = rd_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_data   <= '0;
      res_handle <= '0;
      res_found  <= 1'b0;
      res_status <= ST_OK;
      res_empty  <= (head_after == NIL);
      res_full   <= (count_after >= NIL);
      if (res_kind == RES_HIT) begin
        res_found  <= 1'b1;
        res_handle <= cur[HANDLE_W-1:0];
      end else if (res_kind == RES_PLAIN) begin
        case (cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (st.pool_full) res_status <= ST_FULL;
            else res_handle <= free_head[HANDLE_W-1:0];
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (st.list_empty) res_status <= ST_EMPTY;
            else res_data <= rd_val;
          end
          CMD_DELETE: begin
            if (st.list_empty) res_status <= ST_EMPTY;
            else if (hnd_bad) res_status <= ST_BAD_HND;
            else res_data <= rd_val;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/doubly_linked_list_engine_top.sv =====
// Channel | Signals                      | Fields (lowest bit first)
// s_axis  | tvalid tready tdata[47:0]    | command[2:0] value[34:3] handle[42:35]
// m_axis  | tvalid tready tdata[47:0]    | data nh found status is_empty is_full
//                                          [31:0][39:32][40][42:41][43][44]
// Push, pop and delete: after accept, node memory read, update and result
// register in order, then a done state before the next command is taken.
// Search reads the head node, then walks the list with one node memory read per
// visited node until a match or the end of the list (a miss).
// One command in flight; input ready drops until the result is taken.
// rst is synchronous, active high; empty list, all nodes free.
module doubly_linked_list_engine_top #(
  parameter int NODES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // command, value, handle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // data, node_handle, found, status, is_empty, is_full
);
  import dlle_pkg::*;

  dlle_cmd_t  ctl;
  dlle_stat_t st;
  logic [1:0] res_kind;
  logic [VALUE_W-1:0]  res_data;
  logic [HANDLE_W-1:0] res_handle;
  logic                res_found, res_empty, res_full;
  logic [STATUS_W-1:0] res_status;

  dlle_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .st(st), .ctl(ctl), .res_kind(res_kind)
  );

  dlle_dpath #(.NODES(NODES)) u_dpath (
    .clk(clk), .rst(rst),
    .in_cmd(s_axis_tdata[2:0]),
    .in_value(s_axis_tdata[34:3]),
    .in_handle(s_axis_tdata[42:35]),
    .ctl(ctl), .res_kind(res_kind), .st(st),
    .res_data(res_data), .res_handle(res_handle), .res_found(res_found),
    .res_status(res_status), .res_empty(res_empty), .res_full(res_full)
  );

  assign m_axis_tdata = {3'b000, res_full, res_empty, res_status, res_found,
                         res_handle, res_data};

endmodule
